@@ rtl/ferc_pkg.sv @@
// package: types, constants and status codes for the free extent release block
package ferc_pkg;

	localparam int MaxExtents = 16;
	localparam int AddrWidth  = 32;
	localparam int GranWidth  = 3;
	localparam logic [GranWidth-1:0] GranReset = 3'd3;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_ZERO_LEN = 2'd1,
		ST_OVERLAP  = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	typedef struct packed {
		logic [31:0] region_address;
		logic [31:0] region_length;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [4:0] extents_in_use;
	} rsp_t;

endpackage

@@ rtl/free_extent_release_coalesce_core.sv @@
// top level: sorted free extent table with release and coalescing
//
//  channel | direction | handshake        | payload
//  req     | in        | req_valid/stall  | ferc_pkg::req_t
//  rsp     | out       | rsp_valid/stall  | ferc_pkg::rsp_t
//  cfg     | in        | cfg_we           | granule_log2 (3 bits)
//
// one item at a time; the extent memory has one read port and one write port:
// the scan reads one entry per step, then each entry above the gap is shifted
// one move at a time to open or close the gap, each move a read then a write
// after reset the table is empty and granule_log2 is 3; no clearing pass
// the result waits in an output register; a stalled result holds the next item off
module free_extent_release_coalesce_core #(
	parameter int MAX_EXTENTS = ferc_pkg::MaxExtents,
	parameter int ADDR_WIDTH  = ferc_pkg::AddrWidth
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_wdata,
	input  logic                req_valid,
	output logic                req_stall,
	input  ferc_pkg::req_t      req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output ferc_pkg::rsp_t      rsp
);

	localparam int IW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int AW = ADDR_WIDTH;
	localparam int SW = ADDR_WIDTH + 1;
	localparam int EW = AW + SW;
	localparam int XW = (AW > 34) ? AW + 1 : 35;

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SCAN_W, S_CHECK, S_DECIDE,
		S_SH_RD, S_SH_WR, S_WRITE, S_DONE
	} state_t;

	// extent memory: start and size side by side
	logic [EW-1:0] mem [MAX_EXTENTS];
	logic [IW-1:0] rd_addr, wr_addr;
	logic          rd_en, wr_en;
	logic [EW-1:0] wr_data, rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (rd_en) rd_data_q <= mem[rd_addr];
	end

	state_t          state_q;
	logic [2:0]      gran_q;
	logic [CW-1:0]   count_q;
	logic [XW-1:0]   addr_q, rlen_q, end_q;
	logic [CW-1:0]   idx_q, k_q;
	logic [AW-1:0]   pstart_q;
	logic [SW-1:0]   psize_q, nsize_q;
	logic [AW-1:0]   nstart_q;
	logic            hprev_q, hnext_q;
	logic [1:0]      op_q;
	logic [EW-1:0]   move_q;
	logic [1:0]      status_q;
	logic            rsp_valid_q;

	localparam logic [1:0] OP_BOTH = 2'd0, OP_PREV = 2'd1, OP_NEXT = 2'd2, OP_INS = 2'd3;

	// rounding of the released length
	logic [6:0]    gmask;
	logic [XW-1:0] rlen_c, len_x, addr_x;
	always_comb begin
		gmask  = 7'((8'd1 << gran_q) - 8'd1);
		len_x  = XW'(req.region_length);
		addr_x = XW'(req.region_address);
		rlen_c = (len_x + XW'(gmask)) & ~XW'(gmask);
	end

	logic [AW-1:0] rd_start;
	logic [SW-1:0] rd_size;
	assign rd_start = rd_data_q[EW-1:SW];
	assign rd_size  = rd_data_q[SW-1:0];

	logic [XW:0] pend;
	assign pend = (XW+1)'(pstart_q) + (XW+1)'(psize_q);

	// memory port control
	always_comb begin
		rd_en = 1'b0; rd_addr = '0; wr_en = 1'b0; wr_addr = '0; wr_data = '0;
		unique case (state_q)
			S_SCAN:   begin rd_en = 1'b1; rd_addr = idx_q[IW-1:0]; end
			S_SH_RD:  begin rd_en = 1'b1; rd_addr = k_q[IW-1:0]; end
			S_SH_WR:  begin
				wr_en = 1'b1;
				wr_data = rd_data_q;
				wr_addr = (op_q == OP_INS) ? IW'(k_q + CW'(1)) : IW'(k_q - CW'(1));
			end
			S_WRITE:  begin wr_en = 1'b1; wr_addr = k_q[IW-1:0]; wr_data = move_q; end
			default:  ;
		endcase
	end

	assign req_stall = (state_q != S_IDLE) || rsp_valid_q;
	assign rsp_valid = rsp_valid_q;
	assign rsp.status = status_q;
	assign rsp.extents_in_use = 5'(count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; gran_q <= ferc_pkg::GranReset; count_q <= '0;
			rsp_valid_q <= 1'b0; status_q <= ferc_pkg::ST_OK;
		end else begin
			if (cfg_we) gran_q <= cfg_wdata;
			if (rsp_valid_q && !rsp_stall) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req_valid && !req_stall) begin
					addr_q <= addr_x; rlen_q <= rlen_c; end_q <= addr_x + rlen_c;
					idx_q <= '0; hprev_q <= 1'b0; hnext_q <= 1'b0;
					if (req.region_length == '0) begin
						status_q <= ferc_pkg::ST_ZERO_LEN; state_q <= S_DONE;
					end else if (count_q == '0) begin
						state_q <= S_CHECK;
					end else begin
						state_q <= S_SCAN;
					end
				end
				// scan: one read per entry until a start at or beyond the address, or the end of the table
				S_SCAN: state_q <= S_SCAN_W;
				S_SCAN_W: begin
					if (XW'(rd_start) < addr_q) begin
						hprev_q <= 1'b1; pstart_q <= rd_start; psize_q <= rd_size;
						if (idx_q + CW'(1) == count_q) begin
							idx_q <= idx_q + CW'(1); state_q <= S_CHECK;
						end else begin
							idx_q <= idx_q + CW'(1); state_q <= S_SCAN;
						end
					end else begin
						hnext_q <= 1'b1; nstart_q <= rd_start; nsize_q <= rd_size;
						state_q <= S_CHECK;
					end
				end
				// bounds and overlap checks, then pick the merge form
				S_CHECK: begin
					if ((end_q - XW'(1)) > XW'({AW{1'b1}})) begin
						status_q <= ferc_pkg::ST_OVERLAP; state_q <= S_DONE;
					end else if (hprev_q && pend > (XW+1)'(addr_q)) begin
						status_q <= ferc_pkg::ST_OVERLAP; state_q <= S_DONE;
					end else if (hnext_q && end_q > XW'(nstart_q)) begin
						status_q <= ferc_pkg::ST_OVERLAP; state_q <= S_DONE;
					end else begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					status_q <= ferc_pkg::ST_OK;
					if (hprev_q && pend == (XW+1)'(addr_q) && hnext_q
					    && end_q == XW'(nstart_q)) begin
						op_q <= OP_BOTH;
						move_q <= {pstart_q, SW'(psize_q + SW'(rlen_q) + nsize_q)};
						// merged entry sits just below the scan index
						if (idx_q + CW'(1) < count_q) begin
							k_q <= idx_q + CW'(1); state_q <= S_SH_RD;
						end else begin
							k_q <= idx_q - CW'(1); state_q <= S_WRITE;
						end
					end else if (hprev_q && pend == (XW+1)'(addr_q)) begin
						op_q <= OP_PREV; k_q <= idx_q - CW'(1);
						move_q <= {pstart_q, SW'(psize_q + SW'(rlen_q))};
						state_q <= S_WRITE;
					end else if (hnext_q && end_q == XW'(nstart_q)) begin
						op_q <= OP_NEXT; k_q <= idx_q;
						move_q <= {AW'(addr_q), SW'(nsize_q + SW'(rlen_q))};
						state_q <= S_WRITE;
					end else if (count_q >= CW'(MAX_EXTENTS)) begin
						status_q <= ferc_pkg::ST_FULL; state_q <= S_DONE;
					end else begin
						op_q <= OP_INS;
						move_q <= {AW'(addr_q), SW'(rlen_q)};
						// append at the end needs no shift
						if (count_q > idx_q) begin
							k_q <= count_q - CW'(1); state_q <= S_SH_RD;
						end else begin
							k_q <= idx_q; state_q <= S_WRITE;
						end
					end
				end
				S_SH_RD: state_q <= S_SH_WR;
				// one entry moved per read and write pair
				S_SH_WR: begin
					if (op_q == OP_INS) begin
						if (k_q == idx_q) begin k_q <= idx_q; state_q <= S_WRITE; end
						else begin k_q <= k_q - CW'(1); state_q <= S_SH_RD; end
					end else begin
						if (k_q + CW'(1) >= count_q) begin
							k_q <= idx_q - CW'(1); state_q <= S_WRITE;
						end else begin
							k_q <= k_q + CW'(1); state_q <= S_SH_RD;
						end
					end
				end
				S_WRITE: begin
					if (op_q == OP_INS) count_q <= count_q + CW'(1);
					else if (op_q == OP_BOTH) count_q <= count_q - CW'(1);
					state_q <= S_DONE;
				end
				S_DONE: begin rsp_valid_q <= 1'b1; state_q <= S_IDLE; end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the extent count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_EXTENTS)) else $error("extent count beyond depth");
	// a new item is never taken while a result is held
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> req_stall) else $error("accept while result pending");
	// the count only moves in the final write state
	a_count_write: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != $past(count_q)) |-> ($past(state_q) == S_WRITE))
		else $error("count changed outside write");
	// a result appears only after the closing state
	a_rsp_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result without completion");

endmodule
